FILE: rtl/terminal_key_decoder_assert.svh
// Assertion macros for the terminal key decoder checker.
`ifndef TERMINAL_KEY_DECODER_ASSERT_SVH
`define TERMINAL_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define TKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal key decoder check failed");

// Next-cycle implication, gated off during reset.
`define TKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal key decoder check failed");

`endif

FILE: rtl/tkd_pkg.sv
// Types, codes and byte classification functions for the terminal key decoder.
`default_nettype none

package tkd_pkg;

    typedef enum logic [1:0] {
        OP_FEED  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_UTF8 = 2'd1,
        PH_ESC  = 2'd2,
        PH_SEQ  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        PM_EMPTY         = 3'd0,
        PM_ONE           = 3'd1,
        PM_ONE_SEMI      = 3'd2,
        PM_ONE_SEMI_FIVE = 3'd3,
        PM_THREE         = 3'd4,
        PM_FOUR_EIGHT    = 3'd5,
        PM_SEVEN         = 3'd6,
        PM_OTHER         = 3'd7
    } pm_t;

    typedef enum logic [4:0] {
        KEY_CHAR        = 5'd0,
        KEY_ENTER       = 5'd1,
        KEY_BACKSPACE   = 5'd2,
        KEY_TAB         = 5'd3,
        KEY_HOME        = 5'd4,
        KEY_LEFT        = 5'd5,
        KEY_INTERRUPT   = 5'd6,
        KEY_EOF         = 5'd7,
        KEY_END         = 5'd8,
        KEY_RIGHT       = 5'd9,
        KEY_KILL_TO_END = 5'd10,
        KEY_DOWN        = 5'd11,
        KEY_UP          = 5'd12,
        KEY_CLEAR_LINE  = 5'd13,
        KEY_DELETE_WORD = 5'd14,
        KEY_WORD_LEFT   = 5'd15,
        KEY_WORD_RIGHT  = 5'd16,
        KEY_DELETE      = 5'd17
    } key_kind_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        key_kind_t   kind;
        logic [2:0]  len;
        logic [31:0] text;
    } key_item_t;

    typedef struct packed {
        key_item_t item;
        logic      last;
    } res_t;

    typedef struct packed {
        logic      hit;
        key_kind_t kind;
    } key_hit_t;

    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] CSI_BYTE     = 8'h5B;
    localparam logic [7:0] SS3_BYTE     = 8'h4F;
    localparam logic [7:0] PRINT_LOW    = 8'h20;
    localparam logic [7:0] PARAM_HIGH   = 8'h3F;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_THREE     = 8'h33;
    localparam logic [7:0] CH_FOUR      = 8'h34;
    localparam logic [7:0] CH_FIVE      = 8'h35;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_EIGHT     = 8'h38;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_UP        = 8'h41;
    localparam logic [7:0] CH_DOWN      = 8'h42;
    localparam logic [7:0] CH_RIGHT     = 8'h43;
    localparam logic [7:0] CH_LEFT      = 8'h44;
    localparam logic [7:0] CH_END       = 8'h46;
    localparam logic [7:0] CH_HOME      = 8'h48;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    function automatic key_hit_t control_key(input logic [7:0] b);
        key_hit_t r;
        r.hit  = 1'b1;
        r.kind = KEY_CHAR;
        case (b)
            8'h0D, 8'h0A: r.kind = KEY_ENTER;
            8'h08, 8'h7F: r.kind = KEY_BACKSPACE;
            8'h09:        r.kind = KEY_TAB;
            8'h01:        r.kind = KEY_HOME;
            8'h02:        r.kind = KEY_LEFT;
            8'h03:        r.kind = KEY_INTERRUPT;
            8'h04:        r.kind = KEY_EOF;
            8'h05:        r.kind = KEY_END;
            8'h06:        r.kind = KEY_RIGHT;
            8'h0B:        r.kind = KEY_KILL_TO_END;
            8'h0E:        r.kind = KEY_DOWN;
            8'h10:        r.kind = KEY_UP;
            8'h15:        r.kind = KEY_CLEAR_LINE;
            8'h17:        r.kind = KEY_DELETE_WORD;
            default:      r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // 0 means not a valid lead byte
    function automatic logic [2:0] utf8_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)
            len = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic pm_t next_param(input pm_t pm, input logic [7:0] c);
        pm_t r;
        r = PM_OTHER;
        if (pm == PM_EMPTY) begin
            if (c == CH_ONE)
                r = PM_ONE;
            else if (c == CH_THREE)
                r = PM_THREE;
            else if (c == CH_FOUR || c == CH_EIGHT)
                r = PM_FOUR_EIGHT;
            else if (c == CH_SEVEN)
                r = PM_SEVEN;
        end else if (pm == PM_ONE && c == CH_SEMI) begin
            r = PM_ONE_SEMI;
        end else if (pm == PM_ONE_SEMI && c == CH_FIVE) begin
            r = PM_ONE_SEMI_FIVE;
        end
        return r;
    endfunction

    function automatic key_hit_t final_key(input logic [7:0] c, input pm_t pm);
        key_hit_t r;
        logic     ctl;
        ctl    = (pm == PM_ONE_SEMI_FIVE);
        r.hit  = 1'b1;
        r.kind = KEY_CHAR;
        case (c)
            CH_UP:    r.kind = KEY_UP;
            CH_DOWN:  r.kind = KEY_DOWN;
            CH_RIGHT: r.kind = ctl ? KEY_WORD_RIGHT : KEY_RIGHT;
            CH_LEFT:  r.kind = ctl ? KEY_WORD_LEFT : KEY_LEFT;
            CH_HOME:  r.kind = KEY_HOME;
            CH_END:   r.kind = KEY_END;
            CH_TILDE: begin
                if (pm == PM_ONE || pm == PM_SEVEN)
                    r.kind = KEY_HOME;
                else if (pm == PM_THREE)
                    r.kind = KEY_DELETE;
                else if (pm == PM_FOUR_EIGHT)
                    r.kind = KEY_END;
                else
                    r.hit = 1'b0;
            end
            default:  r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tkd_byte_if.sv
// Input channel: one terminal request of mode and data byte.
`default_nettype none

interface tkd_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/tkd_key_if.sv
// Output channel: one decoded key per request.
`default_nettype none

interface tkd_key_if;
    logic        valid;
    logic        ready;
    logic [4:0]  key_kind;
    logic [2:0]  text_length;
    logic [31:0] text_bytes;
    logic        last_of_run;

    modport source (output valid, output key_kind, output text_length,
                    output text_bytes, output last_of_run, input ready);
    modport sink   (input valid, input key_kind, input text_length,
                    input text_bytes, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/tkd_front.sv
// Front end: takes input requests, decodes the mode and queues commands.
`default_nettype none

module tkd_front import tkd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tkd_byte_if.sink   bytes,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    cmd_t             q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op;
    logic             push;
    logic             pop;

    always_comb
    begin
        case (bytes.mode)
            2'd0:    op = OP_FEED;
            2'd1:    op = OP_FLUSH;
            2'd2:    op = OP_CLEAR;
            default: op = OP_NOP;
        endcase
    end

    assign bytes.ready = (cnt_reg != CNT_W'(QDEPTH));
    // mode three changes nothing, so it never enters the queue
    assign push        = bytes.valid && bytes.ready && (op != OP_NOP);
    assign cmd_valid   = (cnt_reg != '0);
    assign pop         = cmd_valid && cmd_ready;
    assign cmd         = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op   <= op;
            q_reg[wr_ptr_reg].data <= bytes.data_byte;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tkd_back.sv
// Back end: byte sequencer that decodes control, UTF-8 and escape input into keys.
`default_nettype none

module tkd_back import tkd_pkg::*;
#(
    parameter int MAX_PENDING = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    tkd_key_if.source  keys
);

    localparam int HC_W = $clog2(MAX_PENDING + 1);

    phase_t          phase_reg, phase_next;
    logic [HC_W-1:0] hc_reg, hc_next;
    logic [2:0]      exp_reg, exp_next;
    pm_t             pm_reg, pm_next;
    logic [2:0][7:0] held_reg, held_next;
    // work list: the fed byte, or bytes replayed after a bad UTF-8 lead
    logic [2:0][7:0] wq_reg, wq_next;
    logic [1:0]      wq_cnt_reg, wq_cnt_next;
    // newest key waits here until we know whether it ends the run
    logic            hold_valid_reg, hold_valid_next;
    key_item_t       hold_reg, hold_next;
    logic            out_valid_reg, out_valid_next;
    res_t            out_reg, out_next;

    logic [7:0]      b;
    logic [1:0]      n;
    key_hit_t        ck;
    key_hit_t        fk;
    logic [2:0]      u8len;
    logic            ok;
    logic [2:0]      rc;
    logic [31:0]     text;
    logic [2:0]      text_len;
    logic            can_push;
    logic            emit_valid;
    key_item_t       emit_item;

    assign cmd_ready = (wq_cnt_reg == 2'd0) && !hold_valid_reg;
    assign can_push  = !out_valid_reg || keys.ready;

    always_comb
    begin
        b     = wq_reg[0];
        n     = hc_reg[1:0];
        ck    = control_key(b);
        fk    = final_key(b, pm_reg);
        u8len = utf8_len(b);
        ok    = is_cont(b) && (n < 2'd2 || is_cont(held_reg[1]))
                && (n < 2'd3 || is_cont(held_reg[2]));
        rc    = {1'b0, n} + {1'b0, wq_cnt_reg} - 3'd1;
        case (n)
            2'd1:
            begin
                text     = {16'h0, b, held_reg[0]};
                text_len = 3'd2;
            end
            2'd2:
            begin
                text     = {8'h0, b, held_reg[1], held_reg[0]};
                text_len = 3'd3;
            end
            2'd3:
            begin
                text     = {b, held_reg[2], held_reg[1], held_reg[0]};
                text_len = 3'd4;
            end
            default:
            begin
                text     = {24'h0, b};
                text_len = 3'd1;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        hc_next         = hc_reg;
        exp_next        = exp_reg;
        pm_next         = pm_reg;
        held_next       = held_reg;
        wq_next         = wq_reg;
        wq_cnt_next     = wq_cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        emit_valid      = 1'b0;
        emit_item.kind  = KEY_CHAR;
        emit_item.len   = 3'd0;
        emit_item.text  = 32'd0;

        if (out_valid_reg && keys.ready)
            out_valid_next = 1'b0;

        if (cmd_valid && cmd_ready)
        begin
            case (cmd.op)
                OP_FEED:
                begin
                    if (hc_reg >= HC_W'(MAX_PENDING))
                    begin
                        phase_next = PH_IDLE;
                        hc_next    = '0;
                        exp_next   = 3'd0;
                        pm_next    = PM_EMPTY;
                    end
                    else
                    begin
                        wq_next[0]  = cmd.data;
                        wq_cnt_next = 2'd1;
                    end
                end
                OP_FLUSH:
                begin
                    if (phase_reg == PH_ESC || phase_reg == PH_SEQ)
                    begin
                        phase_next = PH_IDLE;
                        hc_next    = '0;
                        exp_next   = 3'd0;
                        pm_next    = PM_EMPTY;
                    end
                end
                OP_CLEAR:
                begin
                    phase_next = PH_IDLE;
                    hc_next    = '0;
                    exp_next   = 3'd0;
                    pm_next    = PM_EMPTY;
                end
                default:
                begin
                end
            endcase
        end
        else if (wq_cnt_reg != 2'd0 && can_push)
        begin
            wq_next[0]  = wq_reg[1];
            wq_next[1]  = wq_reg[2];
            wq_cnt_next = wq_cnt_reg - 2'd1;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == ESC_BYTE)
                    begin
                        phase_next = PH_ESC;
                        hc_next    = HC_W'(1);
                    end
                    else if (ck.hit)
                    begin
                        emit_valid     = 1'b1;
                        emit_item.kind = ck.kind;
                    end
                    else if (b >= PRINT_LOW && u8len == 3'd1)
                    begin
                        emit_valid     = 1'b1;
                        emit_item.len  = 3'd1;
                        emit_item.text = {24'h0, b};
                    end
                    else if (b >= PRINT_LOW && u8len != 3'd0)
                    begin
                        held_next[0] = b;
                        hc_next      = HC_W'(1);
                        exp_next     = u8len;
                        phase_next   = PH_UTF8;
                    end
                end
                PH_UTF8:
                begin
                    if (({1'b0, n} + 3'd1) < exp_reg)
                    begin
                        held_next[n] = b;
                        hc_next      = HC_W'({1'b0, n} + 3'd1);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        hc_next    = '0;
                        exp_next   = 3'd0;
                        pm_next    = PM_EMPTY;
                        if (ok)
                        begin
                            emit_valid     = 1'b1;
                            emit_item.len  = text_len;
                            emit_item.text = text;
                        end
                        else
                        begin
                            // drop the lead, decode the rest again ahead of pending bytes
                            case (n)
                                2'd2:    wq_next = {wq_reg[1], b, held_reg[1]};
                                2'd3:    wq_next = {b, held_reg[2], held_reg[1]};
                                default: wq_next = {wq_reg[2], wq_reg[1], b};
                            endcase
                            wq_cnt_next = rc[1:0];
                        end
                    end
                end
                PH_ESC:
                begin
                    if (b == CSI_BYTE || b == SS3_BYTE)
                    begin
                        phase_next = PH_SEQ;
                        hc_next    = HC_W'(2);
                        pm_next    = PM_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        hc_next    = '0;
                        exp_next   = 3'd0;
                        pm_next    = PM_EMPTY;
                    end
                end
                PH_SEQ:
                begin
                    if (b >= PRINT_LOW && b <= PARAM_HIGH)
                    begin
                        hc_next = hc_reg + HC_W'(1);
                        pm_next = next_param(pm_reg, b);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        hc_next    = '0;
                        exp_next   = 3'd0;
                        pm_next    = PM_EMPTY;
                        if (fk.hit)
                        begin
                            emit_valid     = 1'b1;
                            emit_item.kind = fk.kind;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (emit_valid)
            begin
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next.item  = hold_reg;
                    out_next.last  = 1'b0;
                end
                hold_next       = emit_item;
                hold_valid_next = 1'b1;
            end
        end
        else if (hold_valid_reg && can_push)
        begin
            // work list drained: the held key is the last of its run
            out_valid_next  = 1'b1;
            out_next.item   = hold_reg;
            out_next.last   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hc_reg         <= '0;
            exp_reg        <= 3'd0;
            pm_reg         <= PM_EMPTY;
            wq_cnt_reg     <= 2'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hc_reg         <= hc_next;
            exp_reg        <= exp_next;
            pm_reg         <= pm_next;
            wq_cnt_reg     <= wq_cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        wq_reg   <= wq_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign keys.valid       = out_valid_reg;
    assign keys.key_kind    = out_reg.item.kind;
    assign keys.text_length = out_reg.item.len;
    assign keys.text_bytes  = out_reg.item.text;
    assign keys.last_of_run = out_reg.last;

endmodule

`default_nettype wire

FILE: rtl/terminal_key_decoder.sv
// Top level of the terminal key decoder.
`default_nettype none

// Terminal key decoder. Each input request carries a mode (feed a byte, flush a
// pending escape sequence, clear everything held) and a byte; each output request
// is one key, with last_of_run set on the final key caused by an input. A fed
// byte may yield zero to three keys. Feed, flush and clear requests enter a
// two-entry command queue; the back-end sequencer takes a command, then decodes
// one byte per cycle while the key side does not stall (the fed byte, or up to
// three more when a bad UTF-8 lead is dropped and its followers are replayed),
// then releases the final key; it takes no new command until the work list is
// empty and the final key is released. An escape sequence longer than
// MAX_PENDING held bytes is discarded silently.
module terminal_key_decoder import tkd_pkg::*;
#(
    parameter int MAX_PENDING = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    tkd_byte_if.sink  bytes,
    tkd_key_if.source keys
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    tkd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tkd_back #(
        .MAX_PENDING (MAX_PENDING)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .keys      (keys)
    );

endmodule

`default_nettype wire

FILE: rtl/tkd_checker.sv
// Port-level checker for the terminal key decoder, bound to the top level.
`default_nettype none
`include "terminal_key_decoder_assert.svh"

module tkd_checker import tkd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  key_kind,
    input logic [2:0]  text_length,
    input logic [31:0] text_bytes
);

    `TKD_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid)
    `TKD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(key_kind) && $stable(text_length) && $stable(text_bytes))
    // non-character keys carry no text
    `TKD_ASSERT_IMPL(a_key_no_text, clk, rst_n, out_valid && key_kind != KEY_CHAR, text_length == 3'd0 && text_bytes == 32'd0)
    // characters carry 1 to 4 bytes, top byte only for 4-byte forms
    `TKD_ASSERT_IMPL(a_char_len, clk, rst_n, out_valid && key_kind == KEY_CHAR, text_length != 3'd0 && text_length <= 3'd4 && (text_length == 3'd4 || text_bytes[31:24] == 8'd0))

endmodule

bind terminal_key_decoder tkd_checker u_tkd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (keys.valid),
    .out_ready   (keys.ready),
    .key_kind    (keys.key_kind),
    .text_length (keys.text_length),
    .text_bytes  (keys.text_bytes)
);

`default_nettype wire
